FILE: sv/cms_pkg.sv
// Shared types, constants and rotate helpers of the canonical minimizer stream.
// Used by cms_cell, cms_front and canonical_minimizer_stream.
`default_nettype none
package cms_pkg;
	localparam int MAX_K_DEF = 32;
	localparam int MAX_W_DEF = 64;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KMER_LEN   = 3'd0,
		REG_WINDOW_LEN = 3'd1,
		REG_SEED0      = 3'd2,
		REG_SEED1      = 3'd3,
		REG_SEED2      = 3'd4,
		REG_SEED3      = 3'd5
	} reg_idx_t;

	localparam logic [1:0] COMP_MASK = 2'b10;

	typedef struct packed {
		logic [15:0] key;
		logic [7:0]  lage;
		logic [7:0]  rage;
	} cell_t;

	typedef struct packed {
		logic [31:0] pos;
		logic [15:0] key;
		logic [6:0]  tg;
		logic        kmer_ok;
		logic        emit_ok;
		logic        eos;
	} front_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
		logic [63:0] d;
		d = {x, x} << r;
		return d[63:32];
	endfunction

	function automatic logic [31:0] rotr1(input logic [31:0] x);
		return {x[0], x[31:1]};
	endfunction
endpackage
`default_nettype wire

FILE: sv/canonical_minimizer_stream.sv
// Canonical minimizer stream: one DNA base in per word, new minimizer index out.
// Channel in: base, end_of_sequence with in_valid / in_stall.
// Channel out: min_position with out_valid / out_stall; zero or one word per base.
// Config: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data; write only
// while idle. Indexes: kmer_len, window_len, seed_base0..3.
// Throughput: one base per cycle unless stalled; the window minima sit in a chain
// of MAX_W cells, each a running prefix minimum, so no scan over the window is needed.
// An accepted base passes the stage-one word, the stage-two word, then the output register.
// Stall: out_stall freezes the whole pipe while the output register is full; in_stall
// follows a full output register that is held, and holds the input in the cycle after
// a config write while the history prefetch reloads.
// Reset: hashes, counts and pipe valids clear, the previous minimizer goes to all ones;
// registers go to k=21, w=11, seeds 0. History and cell contents are not cleared.
// End of sequence: the marked base is processed, then stream state clears.
// Depends on cms_pkg, cms_front and cms_cell.
`default_nettype none
module canonical_minimizer_stream #(
	parameter int MAX_K = cms_pkg::MAX_K_DEF,
	parameter int MAX_W = cms_pkg::MAX_W_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                base,
	input  wire logic                      end_of_sequence,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [31:0]                    min_position,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [cms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]               cfg_data
);
	localparam int HD = MAX_K + MAX_W;
	localparam int KW = $clog2(MAX_K + 1);
	localparam int LW = $clog2(HD);
	localparam int AW = (MAX_W > 1) ? $clog2(MAX_W) : 1;

	logic [5:0]  kmer_len_q;
	logic [6:0]  window_len_q;
	logic [31:0] seed_q [4];
	logic        cfg_hold_q;

	logic [31:0] kc, wc, lc;
	logic [KW-1:0] k_eff;
	logic [LW-1:0] l_eff;
	logic [AW-1:0] rd_idx;

	logic advance, take;
	logic v_s1, v_s2;
	cms_pkg::front_t word_s1, word_s2;
	cms_pkg::cell_t  cells [MAX_W];
	cms_pkg::cell_t  pick;
	logic [7:0]  age;
	logic [31:0] chosen, prev_q, min_q;
	logic        out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q   <= 6'd21;
			window_len_q <= 7'd11;
			for (int i = 0; i < 4; i++)
				seed_q[i] <= '0;
		end else if (cfg_valid) begin
			unique case (cms_pkg::reg_idx_t'(cfg_index))
				cms_pkg::REG_KMER_LEN:   kmer_len_q   <= cfg_data[5:0];
				cms_pkg::REG_WINDOW_LEN: window_len_q <= cfg_data[6:0];
				cms_pkg::REG_SEED0:      seed_q[0]    <= cfg_data;
				cms_pkg::REG_SEED1:      seed_q[1]    <= cfg_data;
				cms_pkg::REG_SEED2:      seed_q[2]    <= cfg_data;
				cms_pkg::REG_SEED3:      seed_q[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_hold_q <= 1'b0;
		else
			cfg_hold_q <= cfg_valid && cfg_ready;
	end

	always_comb begin
		kc = 32'(kmer_len_q);
		if (kc == 32'd0) kc = 32'd1;
		if (kc > 32'(MAX_K)) kc = 32'(MAX_K);
		wc = 32'(window_len_q);
		if (wc == 32'd0) wc = 32'd1;
		if (wc > 32'(MAX_W)) wc = 32'(MAX_W);
		lc = kc + wc - 32'd1;
		k_eff = KW'(kc);
		l_eff = LW'(lc);
		rd_idx = AW'(wc - 32'd1);
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance || cfg_hold_q;
	assign take     = advance && in_valid && !cfg_hold_q;

	cms_front #(.MAX_K(MAX_K), .MAX_W(MAX_W)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .base(base),
		.end_of_sequence(end_of_sequence), .k_eff(k_eff), .l_eff(l_eff),
		.seed(seed_q), .word_s1(word_s1)
	);

	for (genvar i = 0; i < MAX_W; i++) begin : g_cell
		cms_cell u_cell (
			.clk(clk),
			.en(advance && v_s1 && word_s1.kmer_ok),
			.prev_valid(i != 0),
			.new_key(word_s1.key),
			.prev(cells[(i == 0) ? 0 : i - 1]),
			.cur(cells[i])
		);
	end

	always_ff @(posedge clk) begin
		if (advance)
			word_s2 <= word_s1;
	end

	always_comb begin
		pick = cells[rd_idx];
		age = (32'({word_s2.tg, 1'b0}) > lc) ? pick.lage : pick.rage;
		chosen = word_s2.pos - 32'(age);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			prev_q      <= '1;
		end else if (advance) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			out_valid_q <= 1'b0;
			if (v_s2 && word_s2.emit_ok && chosen != prev_q) begin
				out_valid_q <= 1'b1;
				prev_q      <= chosen;
			end
			if (v_s2 && word_s2.eos)
				prev_q <= '1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s2 && word_s2.emit_ok)
			min_q <= chosen;
	end

	assign out_valid    = out_valid_q;
	assign min_position = min_q;

`ifndef ASSERT_OFF
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s2) && $past(word_s2.emit_ok))
		else $error("output word without a stage-two word");
	a_odd_span: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s2 && word_s2.emit_ok) |-> l_eff[0])
		else $error("emit flagged with even span");
	a_age_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s2 && word_s2.emit_ok) |-> 32'(age) < wc)
		else $error("minimum age outside window");
`endif
endmodule
`default_nettype wire

FILE: sv/cms_cell.sv
// One window cell: holds the prefix minimum of the newest keys and both tie ages.
// Depends on cms_pkg.
`default_nettype none
module cms_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          prev_valid,
	input  wire logic [15:0]   new_key,
	input  wire cms_pkg::cell_t prev,
	output cms_pkg::cell_t     cur
);
	cms_pkg::cell_t cell_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!prev_valid) begin
				cell_q.key  <= new_key;
				cell_q.lage <= '0;
				cell_q.rage <= '0;
			end else begin
				cell_q.key  <= (new_key <= prev.key) ? new_key : prev.key;
				cell_q.lage <= (new_key < prev.key) ? 8'd0 : prev.lage + 8'd1;
				cell_q.rage <= (new_key <= prev.key) ? 8'd0 : prev.rage + 8'd1;
			end
		end
	end

	assign cur = cell_q;
endmodule
`default_nettype wire

FILE: sv/cms_front.sv
// Front stage: rolling ntHash pair, base history memory, counters.
// Depends on cms_pkg.
`default_nettype none
module cms_front #(
	parameter int MAX_K = cms_pkg::MAX_K_DEF,
	parameter int MAX_W = cms_pkg::MAX_W_DEF,
	localparam int HD = MAX_K + MAX_W,
	localparam int HW = $clog2(HD),
	localparam int KW = $clog2(MAX_K + 1),
	localparam int LW = $clog2(HD)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [1:0]    base,
	input  wire logic          end_of_sequence,
	input  wire logic [KW-1:0] k_eff,
	input  wire logic [LW-1:0] l_eff,
	input  wire logic [31:0]   seed [4],
	output cms_pkg::front_t    word_s1
);
	logic [31:0] fh_q, rh_q, n_q;
	logic [6:0]  tg_q;
	logic [1:0]  hist_q [HD];
	logic [HW-1:0] wp_q;
	logic [1:0]  rem_q, old_q;

	logic [31:0] k32, l32, km1;
	logic [4:0]  rot;
	logic        kmer_ok, drop_ok;
	logic [HW-1:0] nx_slot, ra_rem, ra_old;
	logic [HW:0] t_rem, t_old;
	logic [1:0]  rem, old_b;
	logic [31:0] fo, ro, h;
	logic [6:0]  tg_nx;

	always_comb begin
		k32 = 32'(k_eff);
		l32 = 32'(l_eff);
		km1 = k32 - 32'd1;
		rot = km1[4:0];
		kmer_ok = n_q >= km1;
		drop_ok = n_q >= l32;
		nx_slot = wp_q;
		if (take)
			nx_slot = (wp_q == HW'(HD - 1)) ? '0 : wp_q + HW'(1);
		t_rem = (HW+1)'(nx_slot) + (HW+1)'(HD) - (HW+1)'(km1);
		ra_rem = (t_rem >= (HW+1)'(HD)) ? HW'(t_rem - (HW+1)'(HD)) : HW'(t_rem);
		t_old = (HW+1)'(nx_slot) + (HW+1)'(HD) - (HW+1)'(l32);
		ra_old = (t_old >= (HW+1)'(HD)) ? HW'(t_old - (HW+1)'(HD)) : HW'(t_old);
		rem = (k32 == 32'd1) ? base : rem_q;
		old_b = old_q;
		fo = {fh_q[30:0], fh_q[31]} ^ seed[base];
		ro = cms_pkg::rotr1(rh_q) ^ cms_pkg::rotl(seed[base ^ cms_pkg::COMP_MASK], rot);
		h = fo + ro;
		tg_nx = tg_q + 7'(base[1]);
		if (drop_ok)
			tg_nx = tg_nx - 7'(old_b[1]);
	end

	// prefetch the leaving bases of the next word
	always_ff @(posedge clk) begin
		if (take)
			hist_q[wp_q] <= base;
		rem_q <= (take && km1 == 32'd1) ? base : hist_q[ra_rem];
		old_q <= (take && l32 == 32'd1) ? base : hist_q[ra_old];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.pos     <= n_q - km1;
			word_s1.key     <= h[31:16];
			word_s1.tg      <= tg_nx;
			word_s1.kmer_ok <= kmer_ok;
			word_s1.emit_ok <= l_eff[0] && (n_q >= l32 - 32'd1);
			word_s1.eos     <= end_of_sequence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q <= '0;
			rh_q <= '0;
			n_q  <= '0;
			tg_q <= '0;
			wp_q <= '0;
		end else if (take) begin
			wp_q <= nx_slot;
			if (end_of_sequence) begin
				fh_q <= '0;
				rh_q <= '0;
				n_q  <= '0;
				tg_q <= '0;
			end else begin
				fh_q <= kmer_ok ? (fo ^ cms_pkg::rotl(seed[rem], rot)) : fo;
				rh_q <= kmer_ok ? (ro ^ seed[rem ^ cms_pkg::COMP_MASK]) : ro;
				n_q  <= n_q + 32'd1;
				tg_q <= tg_nx;
			end
		end
	end
endmodule
`default_nettype wire

FILE: bench/tb_canonical_minimizer_stream.sv
// Self-checking bench for canonical_minimizer_stream: directed and random DNA bases with
// random handshake gaps, an in-bench minimizer predictor and an in-order position
// scoreboard. Depends on cms_pkg and the canonical_minimizer_stream RTL.
`default_nettype none
module tb_canonical_minimizer_stream;
	localparam int HIST_DEPTH = 96;
	localparam int WKEY_DEPTH = 64;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 750;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] base;
	logic end_of_sequence;
	logic out_valid;
	logic out_stall;
	logic [31:0] min_position;
	logic cfg_valid;
	logic cfg_ready;
	logic [cms_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	canonical_minimizer_stream u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.base(base), .end_of_sequence(end_of_sequence),
		.out_valid(out_valid), .out_stall(out_stall), .min_position(min_position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [5:0] kmer_reg;
	logic [6:0] win_reg;
	logic [31:0] seed_word [4];
	logic [31:0] fwd_hash, rc_hash;
	logic [1:0] base_hist [HIST_DEPTH];
	logic [15:0] win_keys [WKEY_DEPTH];
	int unsigned bases_seen;
	logic [6:0] tg_count;
	logic [31:0] prev_minimizer;

	logic [31:0] expected_positions [$];
	int mismatches = 0;
	int items_sent = 0;
	bit no_idle = 0;
	bit in_fire = 0, out_fire = 0;
	int hold_cycles = 0;
	int rx_wait = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] spin_l(input logic [31:0] x, input int unsigned r);
		int unsigned s;
		s = r % 32;
		if (s == 0) return x;
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic void clear_stream();
		fwd_hash = 0;
		rc_hash = 0;
		bases_seen = 0;
		tg_count = 0;
		prev_minimizer = '1;
	endfunction

	function automatic void predict_base(input logic [1:0] b, input bit eos);
		int unsigned k, w, l, n, p, win, loff, roff, lkey, rkey, key, chosen;
		logic [31:0] fo, ro;
		logic [1:0] rem;
		k = kmer_reg;
		w = win_reg;
		if (k == 0) k = 1;
		if (k > cms_pkg::MAX_K_DEF) k = cms_pkg::MAX_K_DEF;
		if (w == 0) w = 1;
		if (w > cms_pkg::MAX_W_DEF) w = cms_pkg::MAX_W_DEF;
		l = k + w - 1;
		n = bases_seen;
		base_hist[n % HIST_DEPTH] = b;
		fo = spin_l(fwd_hash, 1) ^ seed_word[b];
		ro = {rc_hash[0], rc_hash[31:1]} ^ spin_l(seed_word[b ^ cms_pkg::COMP_MASK], k - 1);
		if (n >= k - 1) begin
			p = n - (k - 1);
			rem = base_hist[p % HIST_DEPTH];
			win_keys[p % WKEY_DEPTH] = 16'((fo + ro) >> 16);
			fwd_hash = fo ^ spin_l(seed_word[rem], k - 1);
			rc_hash = ro ^ seed_word[rem ^ cms_pkg::COMP_MASK];
		end else begin
			fwd_hash = fo;
			rc_hash = ro;
		end
		tg_count = tg_count + b[1];
		if (n >= l)
			tg_count = tg_count - base_hist[(n - l) % HIST_DEPTH][1];
		if (l[0] && n >= l - 1) begin
			win = n - (l - 1);
			loff = 0;
			roff = 0;
			lkey = 32'h10000;
			rkey = 32'h10000;
			for (int i = 0; i < w; i++) begin
				key = win_keys[(win + i) % WKEY_DEPTH];
				if (key < lkey) begin
					lkey = key;
					loff = i;
				end
				if (key <= rkey) begin
					rkey = key;
					roff = i;
				end
			end
			chosen = win + ((2 * tg_count > l) ? loff : roff);
			if (chosen != prev_minimizer) begin
				expected_positions = {expected_positions, chosen};
				prev_minimizer = chosen;
			end
		end
		bases_seen = n + 1;
		if (eos) clear_stream();
	endfunction

	task automatic send_base(input logic [1:0] b, input bit eos);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		in_valid = 1;
		base = b;
		end_of_sequence = eos;
		do @(posedge clk); while (in_stall);
		predict_base(b, eos);
		items_sent++;
	endtask

	task automatic send_sequence(input int len);
		for (int i = 0; i < len; i++)
			send_base(2'($urandom_range(0, 3)), i == len - 1);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (expected_positions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cms_pkg::reg_idx_t idx, input logic [31:0] d);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			cms_pkg::REG_KMER_LEN: kmer_reg = d[5:0];
			cms_pkg::REG_WINDOW_LEN: win_reg = d[6:0];
			cms_pkg::REG_SEED0: seed_word[0] = d;
			cms_pkg::REG_SEED1: seed_word[1] = d;
			cms_pkg::REG_SEED2: seed_word[2] = d;
			cms_pkg::REG_SEED3: seed_word[3] = d;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic configure(input logic [31:0] k, input logic [31:0] w, input bit rand_seeds);
		drain();
		write_reg(cms_pkg::REG_KMER_LEN, k);
		write_reg(cms_pkg::REG_WINDOW_LEN, w);
		write_reg(cms_pkg::REG_SEED0, rand_seeds ? $urandom : 32'h0);
		write_reg(cms_pkg::REG_SEED1, rand_seeds ? $urandom : 32'hFFFF_FFFF);
		write_reg(cms_pkg::REG_SEED2, rand_seeds ? $urandom : 32'h1234_5678);
		write_reg(cms_pkg::REG_SEED3, rand_seeds ? $urandom : 32'h8000_0001);
	endtask

	task automatic test_reset_defaults();
		send_sequence(8);
	endtask

	task automatic test_directed();
		configure(1, 1, 0);
		send_base(0, 0);
		send_base(1, 0);
		send_base(2, 0);
		send_base(3, 1);
		send_base(3, 1);
		configure(3, 3, 0);
		send_sequence(10);
		configure(2, 1, 0);
		send_sequence(4);
	endtask

	task automatic test_random();
		int k, w, l, sel;
		while (items_sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0: begin k = 0; w = 0; end
				1: begin k = 63; w = 127; end
				2: begin k = 32; w = 64; end
				3: begin k = 1; w = $urandom_range(1, 8); end
				default: begin k = $urandom_range(1, 12); w = $urandom_range(1, 12); end
			endcase
			configure(k, w, 1);
			no_idle = ($urandom_range(0, 3) == 0);
			l = (k == 0 ? 1 : (k > 32 ? 32 : k)) + (w == 0 ? 1 : (w > 64 ? 64 : w)) - 1;
			for (int s = 0; s < 3; s++) begin
				if ($urandom_range(0, 4) == 0)
					send_sequence($urandom_range(1, l));
				else
					send_sequence(l + $urandom_range(0, 40));
			end
			if ($urandom_range(0, 5) == 0) drain();
		end
		no_idle = 0;
	endtask

	task automatic test_backpressure();
		configure(3, 5, 1);
		no_idle = 1;
		@(negedge clk);
		hold_cycles = 400;
		send_sequence(60);
		no_idle = 0;
	endtask

	task automatic test_sender_pause();
		configure(5, 7, 1);
		send_sequence(30);
		drain();
		send_sequence(30);
	endtask

	always @(posedge clk) begin
		in_fire = in_valid && !in_stall;
		out_fire = out_valid && !out_stall;
		if (in_fire || out_fire || cfg_valid) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n && out_fire) begin
			if (expected_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: min_position=%0d", min_position);
			end else begin
				if (min_position !== expected_positions[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("min_position mismatch: expected %0d actual %0d",
							expected_positions[0], min_position);
				end
				void'(expected_positions.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1;
			hold_cycles--;
		end else begin
			if (out_fire) rx_wait = no_idle ? 0 : $urandom_range(0, 14);
			if (rx_wait > 0) begin
				out_stall = 1;
				rx_wait--;
			end else begin
				out_stall = 0;
			end
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		base = 0;
		end_of_sequence = 0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = cms_pkg::REG_KMER_LEN;
		cfg_data = 0;
		kmer_reg = 21;
		win_reg = 11;
		for (int i = 0; i < 4; i++) seed_word[i] = 0;
		for (int i = 0; i < HIST_DEPTH; i++) base_hist[i] = 0;
		for (int i = 0; i < WKEY_DEPTH; i++) win_keys[i] = 0;
		clear_stream();
		repeat (5) @(negedge clk);
		arst_n = 1;
		test_reset_defaults();
		test_directed();
		test_backpressure();
		test_sender_pause();
		test_random();
		drain();
		if (mismatches == 0 && expected_positions.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (expected_positions.size() != 0)
				$display("%0d expected words never arrived", expected_positions.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
